// File: rtl/sha512_pkg.sv
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, round constants and initial hash values for the SHA-512 engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha512_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        too_long;
  } out_item_t;

  typedef enum logic [2:0] {
    WSEL_DATA,
    WSEL_PAD,
    WSEL_MARK,
    WSEL_ZERO,
    WSEL_LEN
  } wsel_t;

  typedef struct packed {
    logic       push;
    wsel_t      wsel;
    logic       count;
    logic       load_vars;
    logic       round;
    logic       add;
    logic       clear;
    logic [6:0] rnd;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] pos;
  } dp_status_t;

  localparam int unsigned ROUNDS = 80;
  localparam logic [63:0] MARK_WORD = 64'h8000000000000000;
  localparam logic [63:0] INIT_HASH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [63:0] round_k(input logic [6:0] t);
    logic [63:0] k;
    unique case (t)
      7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sha512_dp.sv
// ----------------------------------------------------------------------------
// sha512_dp
// Hash, working and schedule registers, byte counter and the round datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_dp import sha512_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   in_data,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  output out_item_t       out_data
);

  logic [63:0] hash_r [8];
  logic [63:0] v_r [8];
  logic [63:0] w_r [16];
  logic [63:0] total_r;
  logic [3:0]  pos_r;
  logic        ovf_r;

  logic [2:0]  cnt;
  logic [63:0] mask;
  logic [6:0]  pad_shift;
  logic [63:0] pad_word;
  logic [63:0] push_word;
  logic [63:0] add_n;
  logic [64:0] total_nxt;
  logic [63:0] w_new;
  logic [63:0] wt;
  logic [63:0] t1;
  logic [63:0] t2;
  logic [63:0] s0w;
  logic [63:0] s1w;
  logic [63:0] bs0;
  logic [63:0] bs1;
  logic [63:0] ch;
  logic [63:0] maj;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  always_comb begin
    cnt       = in_data.byte_count[2:0];
    mask      = ~({64{1'b1}} >> {cnt, 3'b000});
    pad_shift = 7'd56 - {1'b0, cnt, 3'b000};
    pad_word  = (in_data.data_word & mask) | (64'h80 << pad_shift);
    unique case (cmd.wsel)
      WSEL_DATA: push_word = in_data.data_word;
      WSEL_PAD:  push_word = pad_word;
      WSEL_MARK: push_word = MARK_WORD;
      WSEL_ZERO: push_word = '0;
      WSEL_LEN:  push_word = {total_r[60:0], 3'b000};
      default:   push_word = '0;
    endcase
    if (!in_data.last_of_message || in_data.byte_count[3]) begin
      add_n = 64'd8;
    end else begin
      add_n = {61'd0, cnt};
    end
    total_nxt = {1'b0, total_r} + {1'b0, add_n};

    s0w   = rotr(w_r[1], 1) ^ rotr(w_r[1], 8) ^ (w_r[1] >> 7);
    s1w   = rotr(w_r[14], 19) ^ rotr(w_r[14], 61) ^ (w_r[14] >> 6);
    w_new = s1w + w_r[9] + s0w + w_r[0];
    wt    = (cmd.rnd < 7'd16) ? w_r[0] : w_new;
    bs0   = rotr(v_r[0], 28) ^ rotr(v_r[0], 34) ^ rotr(v_r[0], 39);
    bs1   = rotr(v_r[4], 14) ^ rotr(v_r[4], 18) ^ rotr(v_r[4], 41);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + bs1 + ch + round_k(cmd.rnd) + wt;
    t2    = bs0 + maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= INIT_HASH[i];
      total_r <= '0;
      pos_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.count) begin
        total_r <= total_nxt[63:0];
        if (total_nxt[64] || total_nxt[63:61] != 3'd0) ovf_r <= 1'b1;
      end
      if (cmd.push) pos_r <= pos_r + 4'd1;
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= cmd.push ? push_word : wt;
    end
    if (cmd.load_vars) begin
      for (int i = 0; i < 8; i++) v_r[i] <= hash_r[i];
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign status.pos           = pos_r;
  assign out_data.digest_word = hash_r[cmd.idx];
  assign out_data.word_index  = cmd.idx;
  assign out_data.last_word   = (cmd.idx == 3'd7);
  assign out_data.too_long    = ovf_r;

endmodule

`default_nettype wire

// File: rtl/sha512_ctrl.sv
// ----------------------------------------------------------------------------
// sha512_ctrl
// Sequencer for word intake, padding, 80 compression rounds and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_ctrl import sha512_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_FILL,
    ST_INIT,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  state_t     state_r;
  logic [6:0] rnd_r;
  logic [2:0] idx_r;
  logic       end_r;
  logic       mark_r;
  logic       first_r;
  logic       len_r;
  logic       acc;
  logic       at_end;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign acc       = in_valid && in_ready;
  assign at_end    = (status.pos == 4'd15);

  always_comb begin
    cmd      = '0;
    cmd.wsel = WSEL_ZERO;
    cmd.rnd  = rnd_r;
    cmd.idx  = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.push  = acc;
        cmd.count = acc;
        cmd.wsel  = (!in_data.last_of_message || in_data.byte_count[3]) ? WSEL_DATA : WSEL_PAD;
      end
      ST_MARK: begin
        cmd.push = 1'b1;
        cmd.wsel = WSEL_MARK;
      end
      ST_FILL: begin
        cmd.push = 1'b1;
        cmd.wsel = (at_end && !first_r) ? WSEL_LEN : WSEL_ZERO;
      end
      ST_INIT:  cmd.load_vars = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_ADD:   cmd.add = 1'b1;
      ST_OUT:   cmd.clear = out_ready && (idx_r == 3'd7);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
      end_r   <= 1'b0;
      mark_r  <= 1'b0;
      first_r <= 1'b0;
      len_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            end_r   <= in_data.last_of_message;
            mark_r  <= in_data.last_of_message && in_data.byte_count[3];
            first_r <= 1'b1;
            len_r   <= 1'b0;
            if (at_end) begin
              state_r <= ST_INIT;
            end else if (in_data.last_of_message) begin
              state_r <= in_data.byte_count[3] ? ST_MARK : ST_FILL;
            end
          end
        end
        ST_MARK: begin
          mark_r  <= 1'b0;
          state_r <= at_end ? ST_INIT : ST_FILL;
        end
        ST_FILL: begin
          first_r <= 1'b0;
          if (at_end) begin
            len_r   <= !first_r;
            state_r <= ST_INIT;
          end
        end
        ST_INIT: begin
          rnd_r   <= '0;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'(ROUNDS - 1)) state_r <= ST_ADD;
        end
        ST_ADD: begin
          idx_r <= '0;
          if (!end_r) begin
            state_r <= ST_IDLE;
          end else if (len_r) begin
            state_r <= ST_OUT;
          end else if (mark_r) begin
            state_r <= ST_MARK;
          end else begin
            state_r <= ST_FILL;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              end_r   <= 1'b0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/sha512_hash_engine.sv
// ----------------------------------------------------------------------------
// sha512_hash_engine
// A word that does not close a block is shifted into the schedule and counted; a
// word that closes one starts a compression (load, 80 rounds of the single round unit, final add).
// Last item: padding words one per cycle, one or two compressions, then the
// 8 digest words, one per cycle while out_ready is high; no input is taken meanwhile.
// Reset: synchronous, active low; loads the initial hash, clears the counts.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_hash_engine import sha512_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sha512_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sha512_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
